/* src/lcm_trial_division_core_defines.svh */
// Assertion macros for the checker file.
`ifndef LCM_TRIAL_DIVISION_CORE_DEFINES_SVH
`define LCM_TRIAL_DIVISION_CORE_DEFINES_SVH

// Overlapping implication, disabled in reset.
`define LTDC_ASSERT_SAME(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> c) \
    else $error("lcm_trial_division_core: assertion failed");

// Non-overlapping implication, disabled in reset.
`define LTDC_ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> c) \
    else $error("lcm_trial_division_core: assertion failed");

`endif

/* src/lcmtd_pkg.sv */
`timescale 1ns / 1ps

package lcmtd_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int CNT_W = (OPERAND_WIDTH > 2) ? $clog2(OPERAND_WIDTH) : 1;
  localparam int PROD_W = 2 * OPERAND_WIDTH;
  localparam int PC_W = 3;

  typedef struct packed {
    logic [15:0] first_operand;
    logic [15:0] second_operand;
  } operands_t;

  typedef struct packed {
    logic [31:0] lcm_value;
    logic        invalid_operand;
  } result_t;

  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_EUCLID   = 3'd1;
  localparam logic [2:0] OP_DIV_INIT = 3'd2;
  localparam logic [2:0] OP_DIV_STEP = 3'd3;
  localparam logic [2:0] OP_MUL      = 3'd4;

  localparam logic [2:0] COND_NEVER     = 3'd0;
  localparam logic [2:0] COND_ALWAYS    = 3'd1;
  localparam logic [2:0] COND_ZERO      = 3'd2;
  localparam logic [2:0] COND_Y_NONZERO = 3'd3;
  localparam logic [2:0] COND_CNT_MORE  = 3'd4;

  localparam logic [PC_W-1:0] STEP_CHECK    = 3'd0;
  localparam logic [PC_W-1:0] STEP_EUCLID   = 3'd1;
  localparam logic [PC_W-1:0] STEP_DIV_INIT = 3'd2;
  localparam logic [PC_W-1:0] STEP_DIV      = 3'd3;
  localparam logic [PC_W-1:0] STEP_MUL      = 3'd4;
  localparam logic [PC_W-1:0] STEP_EMIT     = 3'd5;
  localparam logic [PC_W-1:0] STEP_REJECT   = 3'd6;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
    logic            fin;
    logic            err;
  } ctrl_t;

  typedef struct packed {
    logic zero_operand;
    logic y_nonzero;
    logic cnt_more;
  } dp_status_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NONE, cond: COND_NEVER, target: STEP_CHECK, fin: 1'b0, err: 1'b0};
    case (pc)
      STEP_CHECK: begin
        w.cond = COND_ZERO;
        w.target = STEP_REJECT;
      end
      STEP_EUCLID: begin
        w.op = OP_EUCLID;
        w.cond = COND_Y_NONZERO;
        w.target = STEP_EUCLID;
      end
      STEP_DIV_INIT: w.op = OP_DIV_INIT;
      STEP_DIV: begin
        w.op = OP_DIV_STEP;
        w.cond = COND_CNT_MORE;
        w.target = STEP_DIV;
      end
      STEP_MUL: w.op = OP_MUL;
      STEP_EMIT: w.fin = 1'b1;
      STEP_REJECT: begin
        w.fin = 1'b1;
        w.err = 1'b1;
      end
      default: begin
        w.fin = 1'b1;
        w.err = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* src/lcmtd_datapath.sv */
`timescale 1ns / 1ps

module lcmtd_datapath (
  input  logic                  clk,
  input  logic                  load,
  input  lcmtd_pkg::operands_t  operands,
  input  logic [2:0]            op,
  output lcmtd_pkg::dp_status_t status,
  output logic [31:0]           lcm_value
);

  localparam int W = lcmtd_pkg::OPERAND_WIDTH;

  logic [W-1:0]                  a_reg;
  logic [W-1:0]                  b_reg;
  logic [W-1:0]                  x;
  logic [W-1:0]                  y;
  logic [W-1:0]                  r;
  logic [W-1:0]                  q;
  logic [lcmtd_pkg::CNT_W-1:0]   cnt;
  logic [lcmtd_pkg::PROD_W-1:0]  prod;
  logic [W:0]                    rem_shift;
  logic [W:0]                    rem_diff;

  assign rem_shift = {r, q[W-1]};
  assign rem_diff  = rem_shift - {1'b0, x};

  always_ff @(posedge clk) begin
    if (load) begin
      a_reg <= W'(operands.first_operand);
      b_reg <= W'(operands.second_operand);
      x     <= W'(operands.first_operand);
      y     <= W'(operands.second_operand);
    end else begin
      case (op)
        lcmtd_pkg::OP_EUCLID: begin
          if (y != '0) begin
            if (x >= y) begin
              x <= x - y;
            end else begin
              x <= y;
              y <= x;
            end
          end
        end
        lcmtd_pkg::OP_DIV_INIT: begin
          r   <= '0;
          q   <= a_reg;
          cnt <= '0;
        end
        lcmtd_pkg::OP_DIV_STEP: begin
          if (!rem_diff[W]) begin
            r <= rem_diff[W-1:0];
            q <= {q[W-2:0], 1'b1};
          end else begin
            r <= rem_shift[W-1:0];
            q <= {q[W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
        lcmtd_pkg::OP_MUL: prod <= lcmtd_pkg::PROD_W'(q) * lcmtd_pkg::PROD_W'(b_reg);
        default: begin
        end
      endcase
    end
  end

  assign status.zero_operand = (a_reg == '0) || (b_reg == '0);
  assign status.y_nonzero    = (y != '0);
  assign status.cnt_more     = (cnt != lcmtd_pkg::CNT_W'(W - 1));
  assign lcm_value           = 32'(prod);

endmodule

/* src/lcm_trial_division_core.sv */
`timescale 1ns / 1ps
// From accept the sequencer runs CHECK, the subtract-or-swap steps of the Euclid loop,
// DIV_INIT, the division loop, MUL and EMIT, then raises done;
// a zero operand goes from CHECK to REJECT and is flagged invalid.
// One item at a time: start is accepted only while busy is low.
// Reset clears the sequencer; busy and done are low after reset.
// The receiver cannot stall: done is a one-cycle strobe.

module lcm_trial_division_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  lcmtd_pkg::operands_t operands,
  output logic                 done,
  output lcmtd_pkg::result_t   result
);

  logic [lcmtd_pkg::PC_W-1:0] pc;
  logic                       running;
  lcmtd_pkg::ctrl_t           ctrl;
  lcmtd_pkg::dp_status_t      status;
  logic                       take;
  logic                       accept;
  logic [2:0]                 dp_op;
  logic [31:0]                lcm_value;

  assign accept = start && !busy;
  assign busy   = running;
  assign ctrl   = lcmtd_pkg::ucode(pc);
  assign dp_op  = running ? ctrl.op : lcmtd_pkg::OP_NONE;

  always_comb begin
    case (ctrl.cond)
      lcmtd_pkg::COND_ALWAYS:    take = 1'b1;
      lcmtd_pkg::COND_ZERO:      take = status.zero_operand;
      lcmtd_pkg::COND_Y_NONZERO: take = status.y_nonzero;
      lcmtd_pkg::COND_CNT_MORE:  take = status.cnt_more;
      default:                   take = 1'b0;
    endcase
  end

  lcmtd_datapath u_datapath (
    .clk       (clk),
    .load      (accept),
    .operands  (operands),
    .op        (dp_op),
    .status    (status),
    .lcm_value (lcm_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= lcmtd_pkg::STEP_CHECK;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        running <= 1'b1;
        pc      <= lcmtd_pkg::STEP_CHECK;
      end else if (running) begin
        pc <= take ? ctrl.target : pc + 1'b1;
        if (ctrl.fin) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Result payload: hold until the next item finishes.
  always_ff @(posedge clk) begin
    if (running && ctrl.fin) begin
      result.lcm_value       <= ctrl.err ? 32'd0 : lcm_value;
      result.invalid_operand <= ctrl.err;
    end
  end

endmodule

/* src/lcmtd_checker.sv */
`timescale 1ns / 1ps
`include "lcm_trial_division_core_defines.svh"

module lcmtd_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input lcmtd_pkg::operands_t operands,
  input logic                 done,
  input lcmtd_pkg::result_t   result
);

  localparam int W = lcmtd_pkg::OPERAND_WIDTH;

  logic accept;
  logic zero_in;

  assign accept  = start && !busy;
  assign zero_in = (W'(operands.first_operand) == '0) || (W'(operands.second_operand) == '0);

  `LTDC_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `LTDC_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `LTDC_ASSERT_SAME(a_invalid_zero, clk, rst, done && result.invalid_operand, (result.lcm_value == 32'd0))
  `LTDC_ASSERT_SAME(a_zero_reject, clk, rst, accept && zero_in, ##3 (done && result.invalid_operand))

endmodule

bind lcm_trial_division_core lcmtd_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .operands (operands),
  .done     (done),
  .result   (result)
);
